// File: rtl/core/fupd_pkg.sv
`default_nettype none

package fupd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RES         = 3;

    localparam logic [3:0] PREFIX_LEN = 4'd7;
    localparam logic [3:0] POS_SLASH  = 4'd7;
    localparam logic [3:0] POS_BODY   = 4'd8;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    typedef struct packed {
        logic [7:0] url_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       has_byte;
        logic       end_of_path;
        logic       bad_prefix;
    } out_t;

    typedef struct packed {
        logic [1:0]             cnt;
        out_t [MAX_RES-1:0]     res;
    } bundle_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h3A;
            3'd5:    c = 8'h2F;
            3'd6:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c >= 8'h61) begin
            t = c - 8'h57;
        end else if (c >= 8'h41) begin
            t = c - 8'h37;
        end else begin
            t = c - 8'h30;
        end
        return t[3:0];
    endfunction

    function automatic out_t mk_res(input logic [7:0] b, input logic has,
                                    input logic eop, input logic bad);
        out_t r;
        r.path_byte   = b;
        r.has_byte    = has;
        r.end_of_path = eop;
        r.bad_prefix  = bad;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/file_url_path_decoder_unit.sv
// A word accepted on s_ is written into the bundle queue; its results then pass
// through the registered output stage of fupd_back before they show on m_.
// Throughput: one URL word per cycle while each word yields at most one result
// and the queue is not full; a word yielding several results holds the result port
// until each is taken; the bundle queue (QUEUE_DEPTH entries) takes words meanwhile.
// Reset: aresetn is synchronous, active low; it clears parser state, queue and
// output valid. No clearing pass.
`default_nettype none

module file_url_path_decoder_unit #(
    parameter int QUEUE_DEPTH = fupd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fupd_pkg::in_t    s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output fupd_pkg::out_t        m_data
);
    import fupd_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    bundle_t q_in;
    bundle_t q_head;

    fupd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_bundle (q_in)
    );

    fupd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    fupd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// File: rtl/core/fupd_front.sv
`default_nettype none

module fupd_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fupd_pkg::in_t    s_data,
    input  wire logic             q_full,
    output logic                  q_push,
    output fupd_pkg::bundle_t     q_bundle
);
    import fupd_pkg::*;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    logic [3:0] pos_reg, pos_next;
    logic [1:0] pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       disc_reg, disc_next;

    logic             acc;
    logic [7:0]       b;
    logic             last;
    logic [1:0]       n;
    out_t [MAX_RES-1:0] res;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign b       = s_data.url_byte;
    assign last    = s_data.is_last;

    always_comb begin
        pos_next  = pos_reg;
        pend_next = pend_reg;
        held_next = held_reg;
        disc_next = disc_reg;
        n         = 2'd0;
        res       = '0;
        if (acc) begin
            if (disc_reg) begin
                if (last) begin
                    disc_next = 1'b0;
                    pos_next  = 4'd0;
                end
            end else if (pos_reg < PREFIX_LEN) begin
                if (b != prefix_char(pos_reg[2:0])) begin
                    res[0] = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                    n      = 2'd1;
                    if (last) begin
                        pos_next = 4'd0;
                    end else begin
                        disc_next = 1'b1;
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                    if (last) begin
                        res[0]   = mk_res(8'h00, 1'b0, 1'b1, pos_next < PREFIX_LEN);
                        n        = 2'd1;
                        pos_next = 4'd0;
                    end
                end
            end else begin
                pos_next = POS_BODY;
                if (!(pos_reg == POS_SLASH && b == CH_SLASH)) begin
                    case (pend_reg)
                        PEND_NONE: begin
                            if (b == CH_PERCENT) begin
                                pend_next = PEND_PCT;
                            end else begin
                                res[n] = mk_res(b, 1'b1, 1'b0, 1'b0);
                                n      = n + 2'd1;
                            end
                        end
                        PEND_PCT: begin
                            if (hex_ok(b)) begin
                                held_next = b;
                                pend_next = PEND_DIGIT;
                            end else begin
                                pend_next = PEND_NONE;
                                res[n]    = mk_res(CH_PERCENT, 1'b1, 1'b0, 1'b0);
                                n         = n + 2'd1;
                                if (b == CH_PERCENT) begin
                                    pend_next = PEND_PCT;
                                end else begin
                                    res[n] = mk_res(b, 1'b1, 1'b0, 1'b0);
                                    n      = n + 2'd1;
                                end
                            end
                        end
                        default: begin
                            pend_next = PEND_NONE;
                            if (hex_ok(b)) begin
                                res[n] = mk_res({hex_val(held_reg), hex_val(b)},
                                                1'b1, 1'b0, 1'b0);
                                n      = n + 2'd1;
                            end else begin
                                res[n] = mk_res(CH_PERCENT, 1'b1, 1'b0, 1'b0);
                                n      = n + 2'd1;
                                res[n] = mk_res(held_reg, 1'b1, 1'b0, 1'b0);
                                n      = n + 2'd1;
                                if (b == CH_PERCENT) begin
                                    pend_next = PEND_PCT;
                                end else begin
                                    res[n] = mk_res(b, 1'b1, 1'b0, 1'b0);
                                    n      = n + 2'd1;
                                end
                            end
                        end
                    endcase
                end
                if (last) begin
                    if (pend_next == PEND_PCT) begin
                        res[n] = mk_res(CH_PERCENT, 1'b1, 1'b0, 1'b0);
                        n      = n + 2'd1;
                    end else if (pend_next == PEND_DIGIT) begin
                        res[n] = mk_res(CH_PERCENT, 1'b1, 1'b0, 1'b0);
                        n      = n + 2'd1;
                        res[n] = mk_res(held_next, 1'b1, 1'b0, 1'b0);
                        n      = n + 2'd1;
                    end
                    if (n == 2'd0) begin
                        res[0] = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
                        n      = 2'd1;
                    end
                    res[n - 2'd1].end_of_path = 1'b1;
                    pos_next  = 4'd0;
                    pend_next = PEND_NONE;
                    held_next = 8'h00;
                end
            end
        end
    end

    assign q_push       = acc && (n != 2'd0);
    assign q_bundle.cnt = n;
    assign q_bundle.res = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 4'd0;
            pend_reg <= PEND_NONE;
            held_reg <= 8'h00;
            disc_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            held_reg <= held_next;
            disc_reg <= disc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fupd_queue.sv
`default_nettype none

module fupd_queue #(
    parameter int DEPTH = fupd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire fupd_pkg::bundle_t  push_data,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output fupd_pkg::bundle_t       head
);
    import fupd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bundle_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue underflow");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/core/fupd_back.sv
`default_nettype none

module fupd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire fupd_pkg::bundle_t  q_head,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fupd_pkg::out_t          m_data
);
    import fupd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    out_t       dat_reg, dat_next;
    logic       load;
    logic       take;

    assign load  = !vld_reg || m_ready;
    assign take  = load && q_valid;
    assign q_pop = take && (idx_reg == q_head.cnt - 2'd1);

    always_comb begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        dat_next = dat_reg;
        if (load) begin
            vld_next = q_valid;
        end
        if (take) begin
            dat_next = q_head.res[idx_reg];
            idx_next = q_pop ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        dat_reg <= dat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    assign m_valid = vld_reg;
    assign m_data  = dat_reg;

    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && dat_reg.bad_prefix) |-> (dat_reg.end_of_path && !dat_reg.has_byte))
        else $error("error word malformed");

    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> (q_head.cnt != 2'd0 && idx_reg < q_head.cnt))
        else $error("result index beyond bundle");

endmodule

`default_nettype wire

// File: dv/file_url_path_decoder_unit_test.sv
module file_url_path_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fupd_pkg::*;

    localparam logic [55:0] SCHEME_TEXT   = "file://";
    localparam int          HOLD_AT_WORD  = 150;
    localparam int          HOLD_CYCLES   = 90;
    localparam int          RANDOM_WORDS  = 225;
    localparam int          TAIL_CYCLES   = 10;

    typedef struct {
        in_t word;
        bit  hold_for_drain;
    } url_word_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    url_word_t  url_words[$];
    out_t       path_expect[$];
    logic [7:0] url_text[$];

    logic [3:0] match_pos   = '0;
    logic [1:0] held_count  = '0;
    logic [7:0] held_char   = '0;
    logic       dropping    = 1'b0;

    int errors       = 0;
    int words_taken  = 0;
    int results_seen = 0;
    int urls_queued  = 0;
    int words_queued = 0;
    int cycle_count  = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit draining     = 1'b0;

    file_url_path_decoder_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] scheme_char(input int pos);
        return SCHEME_TEXT[55 - 8 * pos -: 8];
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic out_t path_res(input logic [7:0] b, input logic has, input logic bad);
        out_t r;
        r.path_byte   = b;
        r.has_byte    = has;
        r.end_of_path = 1'b0;
        r.bad_prefix  = bad;
        return r;
    endfunction

    function automatic void clear_decoder();
        match_pos  = '0;
        held_count = '0;
        held_char  = '0;
        dropping   = 1'b0;
    endfunction

    function automatic void decode_word(input in_t w);
        out_t       batch[$];
        out_t       r;
        logic [7:0] b;
        int         lo;
        bit         rescan;
        b = w.url_byte;
        if (dropping) begin
            if (w.is_last) clear_decoder();
            return;
        end
        if (match_pos < PREFIX_LEN) begin
            if (b != scheme_char(match_pos)) begin
                r = path_res(8'h00, 1'b0, 1'b1);
                r.end_of_path = 1'b1;
                path_expect.push_back(r);
                if (w.is_last) clear_decoder();
                else dropping = 1'b1;
                return;
            end
            match_pos++;
            if (w.is_last) begin
                r = path_res(8'h00, 1'b0, match_pos < PREFIX_LEN);
                r.end_of_path = 1'b1;
                path_expect.push_back(r);
                clear_decoder();
            end
            return;
        end
        rescan = 1'b1;
        if (match_pos == POS_SLASH) begin
            match_pos = POS_BODY;
            if (b == CH_SLASH) rescan = 1'b0;
        end
        if (rescan) begin
            lo = hex_nibble(b);
            if (held_count == 2'd1 && lo >= 0) begin
                held_char  = b;
                held_count = 2'd2;
                rescan     = 1'b0;
            end else if (held_count == 2'd2 && lo >= 0) begin
                batch.push_back(path_res(8'(hex_nibble(held_char) * 16 + lo), 1'b1, 1'b0));
                held_count = 2'd0;
                rescan     = 1'b0;
            end else if (held_count != 2'd0) begin
                batch.push_back(path_res(CH_PERCENT, 1'b1, 1'b0));
                if (held_count == 2'd2) batch.push_back(path_res(held_char, 1'b1, 1'b0));
                held_count = 2'd0;
            end
        end
        if (rescan) begin
            if (b == CH_PERCENT) held_count = 2'd1;
            else batch.push_back(path_res(b, 1'b1, 1'b0));
        end
        if (w.is_last) begin
            if (held_count != 2'd0) batch.push_back(path_res(CH_PERCENT, 1'b1, 1'b0));
            if (held_count == 2'd2) batch.push_back(path_res(held_char, 1'b1, 1'b0));
            if (batch.size() == 0) batch.push_back(path_res(8'h00, 1'b0, 1'b0));
            batch[batch.size() - 1].end_of_path = 1'b1;
            clear_decoder();
        end
        foreach (batch[i]) path_expect.push_back(batch[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        if ((cycle_count / 300) % 3 == 2) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) url_text.push_back(s[i]);
    endtask

    task automatic finish_url(input bit drain_first);
        url_word_t u;
        foreach (url_text[i]) begin
            u.word.url_byte = url_text[i];
            u.word.is_last  = (i == url_text.size() - 1);
            u.hold_for_drain = drain_first && (i == 0);
            url_words.push_back(u);
        end
        words_queued += url_text.size();
        urls_queued++;
        url_text.delete();
    endtask

    task automatic add_random_url(input bit drain_first);
        int         kind;
        int         cut;
        int         body_len;
        int         r;
        logic [7:0] wrong;
        string      digits;
        digits   = "0123456789abcdefABCDEF";
        kind     = $urandom_range(0, 99);
        body_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        if (kind < 82) begin
            add_text("file://");
            if ($urandom_range(0, 1) == 1) url_text.push_back(CH_SLASH);
        end else if (kind < 92) begin
            cut = $urandom_range(0, 6);
            for (int i = 0; i < 7; i++) begin
                if (i == cut) begin
                    do wrong = 8'($urandom_range(1, 255)); while (wrong == scheme_char(i));
                    url_text.push_back(wrong);
                end else begin
                    url_text.push_back(scheme_char(i));
                end
            end
        end else begin
            cut = $urandom_range(1, 6);
            for (int i = 0; i < cut; i++) url_text.push_back(scheme_char(i));
            body_len = 0;
        end
        for (int i = 0; i < body_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) url_text.push_back(CH_PERCENT);
            else if (r < 55) url_text.push_back(digits[$urandom_range(0, 21)]);
            else if (r < 65) url_text.push_back(CH_SLASH);
            else url_text.push_back(8'($urandom_range(1, 255)));
        end
        finish_url(drain_first);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
            draining = 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (url_words.size() == 0) begin
                s_valid <= 1'b0;
            end else if (url_words[0].hold_for_drain) begin
                s_valid <= 1'b0;
                if (draining && path_expect.size() == 0) url_words[0].hold_for_drain = 1'b0;
                draining = 1'b1;
            end else begin
                draining = 1'b0;
                s_valid <= 1'b1;
                s_data  <= url_words[0].word;
                void'(url_words.pop_front());
                send_gap = pick_gap();
            end
        end
    end

    // receiver, with one long hold-off once the run is under way
    always @(posedge aclk) begin
        cycle_count++;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (words_taken >= HOLD_AT_WORD && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (path_expect.size() == 0) begin
                    $display("%0t: expected nothing, got %h", $time, m_data);
                    errors++;
                end else begin
                    want = path_expect.pop_front();
                    check_field("path_byte", want.path_byte, m_data.path_byte);
                    check_field("has_byte", 8'(want.has_byte), 8'(m_data.has_byte));
                    check_field("end_of_path", 8'(want.end_of_path),
                                8'(m_data.end_of_path));
                    check_field("bad_prefix", 8'(want.bad_prefix), 8'(m_data.bad_prefix));
                    results_seen++;
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_data);
                words_taken++;
            end
        end
    end

    initial begin
        int directed_words;
        add_text("fil");
        finish_url(1'b0);
        url_text.push_back(8'h00);
        finish_url(1'b0);
        add_text("fx/");
        finish_url(1'b0);
        add_text("file:///%fA%z%4%41");
        url_text.push_back(8'h00);
        url_text.push_back(8'hFF);
        add_text("%4");
        finish_url(1'b0);
        add_text("file://");
        finish_url(1'b0);
        directed_words = words_queued;
        add_random_url(1'b1);
        while (words_queued < directed_words + RANDOM_WORDS)
            add_random_url($urandom_range(0, 29) == 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (url_words.size() != 0 || s_valid) @(posedge aclk);
        while (path_expect.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Decoded %0d URLs (%0d words) into %0d path results; %0d errors.",
                 urls_queued, words_taken, results_seen, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
